[src/pbip_pkg.sv]
package pbip_pkg;

  typedef enum logic [1:0] {
    KIND_MATRIX = 2'd0,
    KIND_ALPHA  = 2'd1,
    KIND_POINT  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_BEHIND    = 3'd2,
    ST_OFFSCREEN = 3'd3,
    ST_SIZE      = 3'd4
  } status_e;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam int NCOEF = 12;
  // Clip-space values fit in 50 bits signed, their magnitudes in 49 bits.
  localparam int CW = 50;
  localparam int MW = 49;
  localparam int DIV_STAGES = 8;
  localparam int DIV_PER_STAGE = 2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [CW-1:0] W_MIN = 50'sd6554;
  localparam logic signed [32:0] HEAD_RISE = 33'sd4194304;
  localparam logic [30:0] MIN_BOX = 31'd327680;
  localparam logic [13:0] WIDTH_RESET = 14'd1920;
  localparam logic [13:0] HEIGHT_RESET = 14'd1080;

  typedef struct packed {
    logic          sat;
    logic          neg;
    logic [16:0]   q;
    logic [MW:0]   n;
    logic [MW-1:0] d;
  } div_t;

endpackage

[src/projected_box_from_interpolated_point.sv]
// Throughput: one beat per cycle; the 16-bit quotient divide is spread over
// eight stages of two steps each, and the whole pipeline holds on a stall.
// Matrix and alpha beats give no result and update state in pipeline order.
// Reset: view matrix cleared, smoothed alpha set to one, screen 1920 x 1080,
// pipeline empty; no clearing pass is needed.
module projected_box_from_interpolated_point (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [13:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [3:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic [16:0]        alpha_value_i,
  input  logic signed [31:0] prev_x_i,
  input  logic signed [31:0] prev_y_i,
  input  logic signed [31:0] prev_z_i,
  input  logic signed [31:0] cur_x_i,
  input  logic signed [31:0] cur_y_i,
  input  logic signed [31:0] cur_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] box_left_o,
  output logic signed [31:0] box_top_o,
  output logic [30:0]        box_w_o,
  output logic [30:0]        box_h_o
);

  localparam int CW = pbip_pkg::CW;
  localparam int MW = pbip_pkg::MW;
  localparam int NDS = pbip_pkg::DIV_STAGES;

  function automatic pbip_pkg::div_t div_step(pbip_pkg::div_t x);
    pbip_pkg::div_t y;
    y = x;
    y.n = {x.n[MW-1:0], 1'b0};
    y.q = {x.q[15:0], 1'b0};
    if (y.n >= {1'b0, x.d}) begin
      y.n = y.n - {1'b0, x.d};
      y.q[0] = 1'b1;
    end
    return y;
  endfunction

  logic en;

  // state
  logic [13:0] scr_w_q, scr_h_q;
  logic [16:0] alpha_q;
  logic [31:0] mat_q [pbip_pkg::NCOEF];

  // stage A
  logic             a_vld_q;
  pbip_pkg::kind_e  a_kind_q;
  logic [3:0]       a_cidx_q;
  logic [31:0]      a_cval_q;
  logic [16:0]      a_t_q;
  logic [33:0]      a_tt_q;
  logic signed [31:0] a_p_q [3];
  logic signed [32:0] a_dif_q [3];
  logic             a_zero_q;
  logic signed [31:0] p_in [3];
  logic signed [31:0] c_in [3];
  logic [16:0]      t_in;

  // stage B
  logic             b_vld_q;
  pbip_pkg::kind_e  b_kind_q;
  logic [3:0]       b_cidx_q;
  logic [31:0]      b_cval_q;
  logic [32:0]      b_t3_q;
  logic [19:0]      b_q_q;
  logic signed [31:0] b_p_q [3];
  logic signed [32:0] b_dif_q [3];
  logic             b_zero_q;
  logic [50:0]      b_m;
  logic [36:0]      b_t15, b_q32;

  // stage C
  logic             c_vld_q;
  pbip_pkg::kind_e  c_kind_q;
  logic [3:0]       c_cidx_q;
  logic [31:0]      c_cval_q;
  logic signed [31:0] c_p_q [3];
  logic signed [50:0] c_prod_q [3];
  logic             c_zero_q;
  logic [52:0]      c_m;
  logic [16:0]      alpha_d;

  // stage D
  logic             d_vld_q;
  pbip_pkg::kind_e  d_kind_q;
  logic [3:0]       d_cidx_q;
  logic [31:0]      d_cval_q;
  logic signed [32:0] d_c_q [3];
  logic signed [32:0] d_zh_q;
  logic             d_zero_q;
  logic signed [32:0] d_c_d [3];
  logic signed [50:0] d_ip [3];

  // stage E
  logic             e_pt_q;
  logic             e_zero_q;
  logic [46:0]      e_pm_q [3][4];
  logic             e_ps_q [3][4];
  logic signed [31:0] e_m3_q [3];
  logic [46:0]      e_pm_d [3][4];
  logic             e_ps_d [3][4];

  // stage F
  logic             f_pt_q, f_zero_q;
  logic signed [CW-1:0] f_a_q [3];
  logic signed [CW-1:0] f_bf_q [3];
  logic signed [CW-1:0] f_bh_q [3];
  logic signed [CW-1:0] f_a_d [3];
  logic signed [CW-1:0] f_bf_d [3];
  logic signed [CW-1:0] f_bh_d [3];

  // stage G
  logic             g_pt_q, g_zero_q;
  logic signed [CW-1:0] g_cf_q [3];
  logic signed [CW-1:0] g_ch_q [3];

  // stage H
  logic             h_pt_q, h_zero_q;
  logic [MW-1:0]    h_mag_q [4];
  logic             h_neg_q [4];
  logic signed [CW-1:0] h_fw_q, h_hw_q;
  logic signed [CW-1:0] h_src [4];

  // stage I
  logic             i_pt_q;
  pbip_pkg::status_e i_st_q, i_st_d;
  pbip_pkg::div_t [2:0] i_div_q, i_div_d;

  // divider stages
  logic             j_pt_q [NDS];
  pbip_pkg::status_e j_st_q [NDS];
  pbip_pkg::div_t [2:0] j_div_q [NDS];
  pbip_pkg::div_t [2:0] j_div_d [NDS];

  // stage K
  logic             k_pt_q;
  pbip_pkg::status_e k_st_q;
  logic [30:0]      k_s_q [3];
  logic [30:0]      k_s_d [3];

  // stage L
  logic             l_pt_q;
  pbip_pkg::status_e l_st_q;
  logic [30:0]      l_h_q, l_sxh_q, l_syh_q;

  // output stage
  logic             o_vld_q;
  pbip_pkg::status_e o_st_q, o_st_d;
  logic signed [31:0] o_left_q, o_top_q;
  logic [30:0]      o_bw_q, o_h_q;
  logic [32:0]      m_h3;
  logic [30:0]      m_lim;

  assign en = !o_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign p_in[0] = prev_x_i;
  assign p_in[1] = prev_y_i;
  assign p_in[2] = prev_z_i;
  assign c_in[0] = cur_x_i;
  assign c_in[1] = cur_y_i;
  assign c_in[2] = cur_z_i;
  assign t_in = (alpha_value_i > pbip_pkg::ONE_Q16) ? pbip_pkg::ONE_Q16 : alpha_value_i;

  always_comb begin
    b_m = 51'(a_tt_q) * 51'(a_t_q);
    b_t15 = 37'({a_t_q, 4'b0000}) - 37'(a_t_q);
    b_q32 = 37'({a_tt_q, 2'b00}) + 37'({a_tt_q, 1'b0}) + (37'd10 << 32) - (b_t15 << 16);
    c_m = 53'(b_t3_q) * 53'(b_q_q);
    alpha_d = (c_m[52:32] > 21'(pbip_pkg::ONE_Q16)) ? pbip_pkg::ONE_Q16 : c_m[48:32];
    for (int i = 0; i < 3; i++) begin
      d_ip[i] = (c_prod_q[i] >>> 16) + 51'(c_p_q[i]);
      d_c_d[i] = d_ip[i][32:0];
    end
  end

  always_comb begin
    logic [31:0] mm;
    logic [32:0] mx;
    logic signed [32:0] cx;
    logic signed [31:0] mv;
    logic [64:0] pr;
    logic signed [47:0] tv [4];
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        mv = $signed(mat_q[4 * r + ((k == 3) ? 2 : k)]);
        cx = (k == 3) ? d_zh_q : d_c_q[k];
        mm = mv[31] ? 32'(-mv) : 32'(mv);
        mx = cx[32] ? 33'(-cx) : 33'(cx);
        pr = 65'(mm) * 65'(mx);
        e_pm_d[r][k] = pr[62:16];
        e_ps_d[r][k] = mv[31] ^ cx[32];
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        tv[k] = $signed({1'b0, e_pm_q[r][k]});
        if (e_ps_q[r][k]) begin
          tv[k] = -tv[k];
        end
      end
      f_a_d[r] = CW'(tv[0]) + CW'(tv[1]);
      f_bf_d[r] = CW'(tv[2]) + CW'(e_m3_q[r]);
      f_bh_d[r] = CW'(tv[3]) + CW'(e_m3_q[r]);
    end
  end

  assign h_src[0] = g_ch_q[0];
  assign h_src[1] = g_cf_q[1];
  assign h_src[2] = g_ch_q[1];
  assign h_src[3] = g_cf_q[0];

  always_comb begin
    logic wlow, off;
    wlow = (h_fw_q < pbip_pkg::W_MIN) || (h_hw_q < pbip_pkg::W_MIN);
    off = (h_mag_q[3] > h_fw_q[MW-1:0]) || (h_mag_q[1] > h_fw_q[MW-1:0]) ||
          (h_mag_q[0] > h_hw_q[MW-1:0]) || (h_mag_q[2] > h_hw_q[MW-1:0]);
    if (h_zero_q) begin
      i_st_d = pbip_pkg::ST_ZERO;
    end else if (wlow) begin
      i_st_d = pbip_pkg::ST_BEHIND;
    end else if (off) begin
      i_st_d = pbip_pkg::ST_OFFSCREEN;
    end else begin
      i_st_d = pbip_pkg::ST_OK;
    end
    for (int l = 0; l < 3; l++) begin
      i_div_d[l].d = (l == 1) ? h_fw_q[MW-1:0] : h_hw_q[MW-1:0];
      i_div_d[l].n = {1'b0, h_mag_q[l]};
      i_div_d[l].neg = h_neg_q[l];
      i_div_d[l].q = '0;
      i_div_d[l].sat = h_mag_q[l] >= i_div_d[l].d;
    end
  end

  always_comb begin
    for (int g = 0; g < NDS; g++) begin
      for (int l = 0; l < 3; l++) begin
        if (g == 0) begin
          j_div_d[g][l] = i_div_q[l];
        end else begin
          j_div_d[g][l] = j_div_q[(g == 0) ? 0 : g - 1][l];
        end
        for (int s = 0; s < pbip_pkg::DIV_PER_STAGE; s++) begin
          j_div_d[g][l] = div_step(j_div_d[g][l]);
        end
      end
    end
  end

  always_comb begin
    logic [16:0] qf;
    logic [17:0] one;
    logic [31:0] pr;
    for (int l = 0; l < 3; l++) begin
      qf = j_div_q[NDS-1][l].sat ? pbip_pkg::ONE_Q16 : j_div_q[NDS-1][l].q;
      if (j_div_q[NDS-1][l].neg ^ (l != 0)) begin
        one = 18'(pbip_pkg::ONE_Q16) - 18'(qf);
      end else begin
        one = 18'(pbip_pkg::ONE_Q16) + 18'(qf);
      end
      pr = (l == 0) ? 32'(scr_w_q) * 32'(one) : 32'(scr_h_q) * 32'(one);
      k_s_d[l] = pr[31:1];
    end
  end

  always_comb begin
    m_h3 = 33'(l_h_q) + 33'({l_h_q, 1'b0});
    m_lim = {scr_h_q, 17'b0};
    o_st_d = l_st_q;
    if (l_st_q == pbip_pkg::ST_OK &&
        (l_h_q < pbip_pkg::MIN_BOX || m_h3 > 33'(m_lim))) begin
      o_st_d = pbip_pkg::ST_SIZE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= pbip_pkg::WIDTH_RESET;
      scr_h_q <= pbip_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pbip_pkg::REG_WIDTH:  scr_w_q <= cfg_wdata_i;
        pbip_pkg::REG_HEIGHT: scr_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= pbip_pkg::ONE_Q16;
      for (int i = 0; i < pbip_pkg::NCOEF; i++) begin
        mat_q[i] <= '0;
      end
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      a_kind_q <= pbip_pkg::KIND_NONE;
      b_kind_q <= pbip_pkg::KIND_NONE;
      c_kind_q <= pbip_pkg::KIND_NONE;
      d_kind_q <= pbip_pkg::KIND_NONE;
      e_pt_q <= 1'b0;
      f_pt_q <= 1'b0;
      g_pt_q <= 1'b0;
      h_pt_q <= 1'b0;
      i_pt_q <= 1'b0;
      for (int s = 0; s < NDS; s++) begin
        j_pt_q[s] <= 1'b0;
      end
      k_pt_q <= 1'b0;
      l_pt_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      if (b_vld_q && b_kind_q == pbip_pkg::KIND_ALPHA) begin
        alpha_q <= alpha_d;
      end
      if (d_vld_q && d_kind_q == pbip_pkg::KIND_MATRIX && d_cidx_q < 4'(pbip_pkg::NCOEF)) begin
        mat_q[d_cidx_q] <= d_cval_q;
      end
      a_vld_q <= in_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      a_kind_q <= pbip_pkg::kind_e'(kind_i);
      b_kind_q <= a_kind_q;
      c_kind_q <= b_kind_q;
      d_kind_q <= c_kind_q;
      e_pt_q <= d_vld_q && d_kind_q == pbip_pkg::KIND_POINT;
      f_pt_q <= e_pt_q;
      g_pt_q <= f_pt_q;
      h_pt_q <= g_pt_q;
      i_pt_q <= h_pt_q;
      j_pt_q[0] <= i_pt_q;
      for (int s = 1; s < NDS; s++) begin
        j_pt_q[s] <= j_pt_q[s-1];
      end
      k_pt_q <= j_pt_q[NDS-1];
      l_pt_q <= k_pt_q;
      o_vld_q <= l_pt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_cidx_q <= coef_index_i;
      a_cval_q <= coef_value_i;
      a_t_q <= t_in;
      a_tt_q <= 34'(t_in) * 34'(t_in);
      a_zero_q <= (cur_x_i == '0) && (cur_y_i == '0) && (cur_z_i == '0);
      for (int i = 0; i < 3; i++) begin
        a_p_q[i] <= p_in[i];
        a_dif_q[i] <= 33'(c_in[i]) - 33'(p_in[i]);
      end
      b_cidx_q <= a_cidx_q;
      b_cval_q <= a_cval_q;
      b_t3_q <= b_m[48:16];
      b_q_q <= b_q32[35:16];
      b_zero_q <= a_zero_q;
      b_p_q <= a_p_q;
      b_dif_q <= a_dif_q;
      c_cidx_q <= b_cidx_q;
      c_cval_q <= b_cval_q;
      c_zero_q <= b_zero_q;
      c_p_q <= b_p_q;
      for (int i = 0; i < 3; i++) begin
        c_prod_q[i] <= b_dif_q[i] * $signed({1'b0, alpha_q});
      end
      d_cidx_q <= c_cidx_q;
      d_cval_q <= c_cval_q;
      d_zero_q <= c_zero_q;
      d_c_q <= d_c_d;
      d_zh_q <= d_c_d[2] + pbip_pkg::HEAD_RISE;
      e_zero_q <= d_zero_q;
      e_pm_q <= e_pm_d;
      e_ps_q <= e_ps_d;
      for (int r = 0; r < 3; r++) begin
        e_m3_q[r] <= $signed(mat_q[4 * r + 3]);
      end
      f_zero_q <= e_zero_q;
      f_a_q <= f_a_d;
      f_bf_q <= f_bf_d;
      f_bh_q <= f_bh_d;
      g_zero_q <= f_zero_q;
      for (int r = 0; r < 3; r++) begin
        g_cf_q[r] <= f_a_q[r] + f_bf_q[r];
        g_ch_q[r] <= f_a_q[r] + f_bh_q[r];
      end
      h_zero_q <= g_zero_q;
      for (int l = 0; l < 4; l++) begin
        h_neg_q[l] <= h_src[l][CW-1];
        h_mag_q[l] <= h_src[l][CW-1] ? MW'(-h_src[l]) : MW'(h_src[l]);
      end
      h_fw_q <= g_cf_q[2];
      h_hw_q <= g_ch_q[2];
      i_st_q <= i_st_d;
      i_div_q <= i_div_d;
      j_st_q[0] <= i_st_q;
      for (int s = 1; s < NDS; s++) begin
        j_st_q[s] <= j_st_q[s-1];
      end
      j_div_q <= j_div_d;
      k_st_q <= j_st_q[NDS-1];
      k_s_q <= k_s_d;
      l_st_q <= k_st_q;
      l_sxh_q <= k_s_q[0];
      l_syh_q <= k_s_q[2];
      l_h_q <= (k_s_q[1] >= k_s_q[2]) ? k_s_q[1] - k_s_q[2] : k_s_q[2] - k_s_q[1];
      o_st_q <= o_st_d;
      if (o_st_d == pbip_pkg::ST_OK) begin
        o_left_q <= $signed(32'(l_sxh_q) - 32'(l_h_q[30:2]));
        o_top_q <= $signed(32'(l_syh_q));
        o_bw_q <= {1'b0, l_h_q[30:1]};
        o_h_q <= l_h_q;
      end else begin
        o_left_q <= '0;
        o_top_q <= '0;
        o_bw_q <= '0;
        o_h_q <= '0;
      end
    end
  end

  assign out_valid_o = o_vld_q;
  assign status_o = o_st_q;
  assign box_left_o = o_left_q;
  assign box_top_o = o_top_q;
  assign box_w_o = o_bw_q;
  assign box_h_o = o_h_q;

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_st_q != pbip_pkg::ST_OK |->
      o_left_q == '0 && o_top_q == '0 && o_bw_q == '0 && o_h_q == '0)
    else $error("rejected result carries a nonzero box");

  a_half_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_st_q == pbip_pkg::ST_OK |-> o_bw_q == {1'b0, o_h_q[30:1]})
    else $error("box width is not half the height");

  a_min_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_st_q == pbip_pkg::ST_OK |-> o_h_q >= pbip_pkg::MIN_BOX)
    else $error("accepted box below minimum height");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alpha_q <= pbip_pkg::ONE_Q16)
    else $error("smoothed alpha above one");

endmodule
